// ===== rtl/jfsf_pkg.sv =====
// package for the jpeg frame size finder: phase codes, status codes and constants
package jfsf_pkg;

	// parser phases
	typedef enum logic [3:0] {
		PH_MAGIC  = 4'd0,
		PH_APPLEN = 4'd1,
		PH_TAG    = 4'd2,
		PH_SKIP   = 4'd3,
		PH_MARKER = 4'd4,
		PH_SEGLEN = 4'd5,
		PH_FRMLEN = 4'd6,
		PH_PREC   = 4'd7,
		PH_HEIGHT = 4'd8,
		PH_WIDTH  = 4'd9
	} phase_t;

	// result status codes
	localparam logic [2:0] ST_FOUND      = 3'd0;
	localparam logic [2:0] ST_BAD_START  = 3'd1;
	localparam logic [2:0] ST_NOT_JFIF   = 3'd2;
	localparam logic [2:0] ST_BAD_MARKER = 3'd3;
	localparam logic [2:0] ST_END_DATA   = 3'd4;

	// file constants
	localparam logic [31:0] START_WORD = 32'hFFD8_FFE0;
	localparam logic [31:0] JFIF_WORD  = 32'h4A46_4946;
	localparam logic [15:0] MARK_MASK  = 16'hFF00;
	localparam logic [15:0] FRAME_MARK = 16'hFFC0;
	localparam logic [15:0] FAIL_SIZE  = 16'd100;
	localparam logic [15:0] TAG_BYTES  = 16'd6;
	localparam logic [15:0] LEN_BYTES  = 16'd2;

	// field byte counts
	localparam logic [2:0] FC_WORD = 3'd4;
	localparam logic [2:0] FC_HALF = 3'd2;

endpackage

// ===== rtl/jpeg_frame_size_finder.sv =====
// jpeg frame size finder: walks jfif marker segments and reports the sof0 size
//
// channel  | valid         | stall         | payload
// ---------+---------------+---------------+---------------------------
// bytes    | byte_valid    | byte_stall    | data_byte, last_byte
// results  | result_valid  | result_stall  | status, width, height
//
// one byte is taken per cycle while byte_stall is low; each byte is held in an
// input register, then the parser state and the result register are updated
// from it; a result is registered from its deciding or final byte.
// byte_stall rises only while a byte waits in the input register and the
// result register holds an item that is stalled.
// arst_n clears all control state; every final byte returns the parser to start.
module jpeg_frame_size_finder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic [15:0] width,
	output logic [15:0] height
);
	import jfsf_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	phase_t      phase_q, phase_d;
	logic [2:0]  count_q, count_d;
	logic [31:0] gather_q, gather_d;
	logic [15:0] skip_q, skip_d;
	logic [15:0] height_q, height_d;
	logic        decided_q, decided_d;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [15:0] width_q, height_out_q;

	logic        out_free, step;
	logic        emit;
	logic [2:0]  emit_status;
	logic [15:0] emit_w, emit_h;
	logic [31:0] gather_n;
	logic [2:0]  count_n;
	logic [15:0] tag_rest, seg_rest, skip_dec;

	// handshake
	assign out_free   = !out_valid_q || !result_stall;
	assign step       = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// shifted field and helper differences
	assign gather_n = {gather_q[23:0], byte_s1};
	assign count_n  = count_q + 3'd1;
	assign tag_rest = skip_q - TAG_BYTES;
	assign seg_rest = gather_n[15:0] - LEN_BYTES;
	assign skip_dec = (skip_q != 16'd0) ? skip_q - 16'd1 : 16'd0;

	// parser step for one item
	always_comb begin
		phase_d     = phase_q;
		count_d     = count_n;
		gather_d    = gather_n;
		skip_d      = skip_q;
		height_d    = height_q;
		decided_d   = decided_q;
		emit        = 1'b0;
		emit_status = ST_END_DATA;
		emit_w      = FAIL_SIZE;
		emit_h      = FAIL_SIZE;
		if (decided_q) begin
			count_d  = count_q;
			gather_d = gather_q;
		end else begin
			case (phase_q)
				PH_MAGIC: begin
					if (count_n == FC_WORD) begin
						if (gather_n != START_WORD) begin
							emit = 1'b1;
							emit_status = ST_BAD_START;
						end else begin
							phase_d = PH_APPLEN;
							count_d = '0;
							gather_d = '0;
						end
					end
				end
				PH_APPLEN: begin
					if (count_n == FC_HALF) begin
						skip_d = gather_n[15:0];
						phase_d = PH_TAG;
						count_d = '0;
						gather_d = '0;
					end
				end
				PH_TAG: begin
					if (count_n == FC_WORD) begin
						if (gather_n != JFIF_WORD) begin
							emit = 1'b1;
							emit_status = ST_NOT_JFIF;
						end else if (skip_q < TAG_BYTES) begin
							emit = 1'b1;
							emit_status = ST_BAD_START;
						end else begin
							skip_d = tag_rest;
							phase_d = (tag_rest != 16'd0) ? PH_SKIP : PH_MARKER;
							count_d = '0;
							gather_d = '0;
						end
					end
				end
				PH_SKIP: begin
					count_d = '0;
					gather_d = '0;
					skip_d = skip_dec;
					if (skip_dec == 16'd0) begin
						phase_d = PH_MARKER;
					end
				end
				PH_MARKER: begin
					if (count_n == FC_HALF) begin
						if ((gather_n[15:0] & MARK_MASK) != MARK_MASK) begin
							emit = 1'b1;
							emit_status = ST_BAD_MARKER;
						end else begin
							phase_d = (gather_n[15:0] == FRAME_MARK) ? PH_FRMLEN : PH_SEGLEN;
							count_d = '0;
							gather_d = '0;
						end
					end
				end
				PH_SEGLEN: begin
					if (count_n == FC_HALF) begin
						if (gather_n[15:0] < LEN_BYTES) begin
							emit = 1'b1;
							emit_status = ST_BAD_MARKER;
						end else begin
							skip_d = seg_rest;
							phase_d = (seg_rest != 16'd0) ? PH_SKIP : PH_MARKER;
							count_d = '0;
							gather_d = '0;
						end
					end
				end
				PH_FRMLEN: begin
					if (count_n == FC_HALF) begin
						phase_d = PH_PREC;
						count_d = '0;
						gather_d = '0;
					end
				end
				PH_PREC: begin
					phase_d = PH_HEIGHT;
					count_d = '0;
					gather_d = '0;
				end
				PH_HEIGHT: begin
					if (count_n == FC_HALF) begin
						height_d = gather_n[15:0];
						phase_d = PH_WIDTH;
						count_d = '0;
						gather_d = '0;
					end
				end
				PH_WIDTH: begin
					if (count_n == FC_HALF) begin
						emit = 1'b1;
						emit_status = ST_FOUND;
						emit_w = gather_n[15:0];
						emit_h = height_q;
					end
				end
				default: begin
					emit = 1'b1;
					emit_status = ST_BAD_MARKER;
				end
			endcase
			// final byte with nothing decided
			if (!emit && last_s1) begin
				emit = 1'b1;
				emit_status = ST_END_DATA;
			end
			if (emit) begin
				decided_d = 1'b1;
			end
		end
		// every final byte restarts the parser
		if (last_s1) begin
			phase_d   = PH_MAGIC;
			count_d   = '0;
			gather_d  = '0;
			skip_d    = '0;
			height_d  = '0;
			decided_d = 1'b0;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_MAGIC;
			count_q   <= '0;
			gather_q  <= '0;
			skip_q    <= '0;
			height_q  <= '0;
			decided_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			count_q   <= count_d;
			gather_q  <= gather_d;
			skip_q    <= skip_d;
			height_q  <= height_d;
			decided_q <= decided_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			status_q     <= emit_status;
			width_q      <= emit_w;
			height_out_q <= emit_h;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = status_q;
	assign width        = width_q;
	assign height       = height_out_q;

endmodule
